/* src/nsp_pkg.sv */
package nsp_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int DEFAULT_COUNT_BITS = 16;

  localparam int CH_BITS = 8;
  localparam int BASE_BITS = 6;
  localparam int OUT_VALUE_BITS = 32;
  localparam int OUT_COUNT_BITS = 16;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNED_MODE = 1'd1;

  localparam logic [BASE_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] RADIX_MAX = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX = 6'd16;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   negative;
    logic   wrapped;
  } ctrl_t;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               last_char;
  } in_item_t;

  typedef struct packed {
    logic [OUT_VALUE_BITS-1:0] value;
    logic [OUT_COUNT_BITS-1:0] consumed;
    logic                      overflow;
  } out_item_t;

endpackage

/* src/nsp_step.sv */
module nsp_step import nsp_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic [CH_BITS-1:0]    ch,
  input  logic [BASE_BITS-1:0]  radix,
  input  logic                  signed_mode,
  input  ctrl_t                 ctrl,
  input  logic [BASE_BITS-1:0]  base,
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [COUNT_BITS-1:0] cnt,
  output ctrl_t                 ctrl_next,
  output logic [BASE_BITS-1:0]  base_next,
  output logic [VALUE_BITS-1:0] acc_next,
  output logic [COUNT_BITS-1:0] cnt_next
);

  localparam int FULL_BITS = VALUE_BITS + BASE_BITS + 1;

  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB = 8'h09;
  localparam logic [CH_BITS-1:0] CH_CR = 8'h0D;
  localparam logic [CH_BITS-1:0] CH_PLUS = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_0 = 8'h30;
  localparam logic [CH_BITS-1:0] CH_9 = 8'h39;
  localparam logic [CH_BITS-1:0] CH_UA = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UX = 8'h58;
  localparam logic [CH_BITS-1:0] CH_UZ = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_LA = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LX = 8'h78;
  localparam logic [CH_BITS-1:0] CH_LZ = 8'h7A;
  localparam logic [CH_BITS-1:0] CH_NUL = 8'h00;
  localparam logic [CH_BITS-1:0] LETTER_OFS = 8'd10;

  logic [BASE_BITS-1:0] sat_radix;
  logic                 is_space;
  logic                 is_sign;
  logic                 is_x;
  logic                 is_dig;
  logic [BASE_BITS-1:0] dig;
  logic                 pf_zero;
  logic [BASE_BITS-1:0] pf_base;
  logic                 do_digit;
  logic [BASE_BITS-1:0] step_base;
  logic                 take;
  logic                 dig_ok;
  logic [FULL_BITS-1:0] full;

  always_comb begin
    sat_radix = (radix > RADIX_MAX) ? RADIX_MAX : radix;
    is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
    is_x = (ch == CH_LX) || (ch == CH_UX);

    if (ch >= CH_0 && ch <= CH_9) begin
      is_dig = 1'b1;
      dig = BASE_BITS'(ch - CH_0);
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      is_dig = 1'b1;
      dig = BASE_BITS'(ch - CH_UA + LETTER_OFS);
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      is_dig = 1'b1;
      dig = BASE_BITS'(ch - CH_LA + LETTER_OFS);
    end else begin
      is_dig = 1'b0;
      dig = '0;
    end

    // A leading zero may still turn into a hex prefix, so it is held apart.
    pf_zero = ((sat_radix == '0) || (sat_radix == BASE_HEX)) && (ch == CH_0);
    pf_base = (sat_radix == '0) ? BASE_DEC : sat_radix;

    ctrl_next = ctrl;
    base_next = base;
    do_digit = 1'b0;
    step_base = base;
    take = 1'b0;

    case (ctrl.phase)
      PH_SPACE, PH_PREFIX: begin
        if (ctrl.phase == PH_SPACE && is_space) begin
          take = 1'b1;
        end else if (ctrl.phase == PH_SPACE && signed_mode && is_sign) begin
          ctrl_next.negative = (ch == CH_MINUS);
          ctrl_next.phase = PH_PREFIX;
          take = 1'b1;
        end else if (pf_zero) begin
          base_next = sat_radix;
          ctrl_next.phase = PH_ZERO;
          take = 1'b1;
        end else begin
          base_next = pf_base;
          step_base = pf_base;
          ctrl_next.phase = PH_DIGITS;
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        ctrl_next.phase = PH_DIGITS;
        if (is_x) begin
          base_next = BASE_HEX;
          take = 1'b1;
        end else begin
          base_next = (base == '0) ? BASE_OCT : base;
          step_base = (base == '0) ? BASE_OCT : base;
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (ch == CH_NUL) begin
          ctrl_next.phase = PH_STOP;
        end else begin
          do_digit = 1'b1;
        end
      end
      default: begin
      end
    endcase

    dig_ok = is_dig && (step_base != '0) && (dig < step_base);
    full = FULL_BITS'(acc) * FULL_BITS'(step_base) + FULL_BITS'(dig);
    acc_next = acc;

    if (do_digit) begin
      if (dig_ok) begin
        acc_next = full[VALUE_BITS-1:0];
        ctrl_next.wrapped = ctrl.wrapped || (|full[FULL_BITS-1:VALUE_BITS]);
        take = 1'b1;
      end else begin
        ctrl_next.phase = PH_STOP;
      end
    end

    cnt_next = (take && cnt != '1) ? cnt + 1'b1 : cnt;
  end

endmodule

/* src/number_string_parser.sv */
// Parses one integer from a stream of characters, one character per item, in the
// manner of strtol: leading whitespace, an optional sign in signed mode, a 0x
// prefix when radix is 0 or 16 or automatic octal/decimal choice when radix is 0,
// then digits below the base. One result item leaves on the item marked last_char,
// with the value, the number of characters consumed and an overflow flag. The block
// takes one item every cycle while its input is not stalled; the last character of a
// string is worked on from the input register and its result is registered, and the
// per-character work is one multiply by the base and an add. The input stalls only
// while a last character waits behind a result that has not been taken. The radix
// is latched at the first character of a string after whitespace and any sign.
module number_string_parser import nsp_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int WIDE_VALUE = 64;
  localparam int WIDE_COUNT = 32;

  logic [BASE_BITS-1:0]  radix;
  logic                  signed_mode;

  logic                  s1_valid;
  in_item_t              s1_item;

  ctrl_t                 ctrl;
  logic [BASE_BITS-1:0]  base;
  logic [VALUE_BITS-1:0] acc;
  logic [COUNT_BITS-1:0] cnt;

  ctrl_t                 ctrl_next;
  logic [BASE_BITS-1:0]  base_next;
  logic [VALUE_BITS-1:0] acc_next;
  logic [COUNT_BITS-1:0] cnt_next;

  logic                  out_free;
  logic                  s1_fire;
  logic                  s1_end;
  logic [VALUE_BITS-1:0] signed_val;
  logic [WIDE_VALUE-1:0] wide_val;
  logic [WIDE_COUNT-1:0] wide_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
      signed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIX: radix <= cfg_data;
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  nsp_step #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .ch         (s1_item.ch),
    .radix      (radix),
    .signed_mode(signed_mode),
    .ctrl       (ctrl),
    .base       (base),
    .acc        (acc),
    .cnt        (cnt),
    .ctrl_next  (ctrl_next),
    .base_next  (base_next),
    .acc_next   (acc_next),
    .cnt_next   (cnt_next)
  );

  // Only an item that produces a result has to wait for the output register.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire = s1_valid && (!s1_item.last_char || out_free);
  assign s1_end = s1_fire && s1_item.last_char;
  assign in_stall = s1_valid && !s1_fire;

  assign signed_val = ctrl_next.negative ? (VALUE_BITS'(0) - acc_next) : acc_next;
  assign wide_val = WIDE_VALUE'(signed_val);
  assign wide_cnt = WIDE_COUNT'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '{phase: PH_SPACE, negative: 1'b0, wrapped: 1'b0};
      base <= '0;
      acc <= '0;
      cnt <= '0;
    end else if (s1_end) begin
      ctrl <= '{phase: PH_SPACE, negative: 1'b0, wrapped: 1'b0};
      base <= '0;
      acc <= '0;
      cnt <= '0;
    end else if (s1_fire) begin
      ctrl <= ctrl_next;
      base <= base_next;
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_end) begin
      out_item.value <= wide_val[OUT_VALUE_BITS-1:0];
      out_item.consumed <= wide_cnt[OUT_COUNT_BITS-1:0];
      out_item.overflow <= ctrl_next.wrapped;
    end
  end

  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    s1_end |=> (ctrl.phase == PH_SPACE) && (acc == '0) && (cnt == '0) && !ctrl.wrapped)
    else $error("parser state not cleared after the last character");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_end |=> out_valid)
    else $error("last character did not produce a result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_item.last_char && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_item.last_char && (ctrl.phase == PH_STOP) |=> ctrl.phase == PH_STOP)
    else $error("parsing resumed after it stopped");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    ctrl.wrapped && !s1_end |=> ctrl.wrapped)
    else $error("overflow flag dropped within a string");

endmodule

/* tb/testbench.sv */
module testbench;
  import nsp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  number_string_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  in_item_t pending_chars[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  logic hold_off = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  event pressure_go;

  // Shadow copy of the registers and of the parse in progress.
  logic [BASE_BITS-1:0] radix_cfg = RADIX_RESET;
  logic signed_cfg = 1'b1;
  phase_t scan_phase = PH_SPACE;
  logic [BASE_BITS-1:0] num_base = '0;
  logic num_negative = 1'b0;
  logic [OUT_VALUE_BITS-1:0] num_acc = '0;
  logic [OUT_COUNT_BITS-1:0] chars_taken = '0;
  logic num_wrapped = 1'b0;

  function automatic void count_taken();
    if (chars_taken != '1) chars_taken++;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [5:0] d;
    logic [63:0] grown;
    if (c >= "0" && c <= "9") d = 6'(c - "0");
    else if (c >= "A" && c <= "Z") d = 6'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "z") d = 6'(c - "a" + 8'd10);
    else begin
      scan_phase = PH_STOP;
      return;
    end
    if (num_base == 0 || d >= num_base) begin
      scan_phase = PH_STOP;
      return;
    end
    if (64'(num_acc) > (64'hFFFF_FFFF - 64'(d)) / 64'(num_base)) num_wrapped = 1'b1;
    grown = 64'(num_acc) * 64'(num_base) + 64'(d);
    num_acc = grown[OUT_VALUE_BITS-1:0];
    count_taken();
  endfunction

  // First character after whitespace and sign: picks the base, or holds a
  // leading zero that may turn out to start a hex prefix.
  function automatic void open_number(input logic [7:0] c);
    logic [BASE_BITS-1:0] b;
    b = (radix_cfg > RADIX_MAX) ? RADIX_MAX : radix_cfg;
    if ((b == 0 || b == BASE_HEX) && c == "0") begin
      num_base = b;
      count_taken();
      scan_phase = PH_ZERO;
      return;
    end
    num_base = (b == 0) ? BASE_DEC : b;
    scan_phase = PH_DIGITS;
    add_digit(c);
  endfunction

  function automatic bit parse_char(input in_item_t it, output out_item_t res);
    logic [7:0] c;
    c = it.ch;
    case (scan_phase)
      PH_SPACE: begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_TAB + 8'd4)) begin
          count_taken();
        end else if (signed_cfg && (c == "+" || c == "-")) begin
          num_negative = (c == "-");
          count_taken();
          scan_phase = PH_PREFIX;
        end else begin
          open_number(c);
        end
      end
      PH_PREFIX: open_number(c);
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          num_base = BASE_HEX;
          count_taken();
          scan_phase = PH_DIGITS;
        end else begin
          if (num_base == 0) num_base = BASE_OCT;
          scan_phase = PH_DIGITS;
          add_digit(c);
        end
      end
      PH_DIGITS: begin
        if (c == CHAR_NUL) scan_phase = PH_STOP;
        else add_digit(c);
      end
      default: ;
    endcase
    if (!it.last_char) return 1'b0;
    res.value = num_negative ? ('0 - num_acc) : num_acc;
    res.consumed = chars_taken;
    res.overflow = num_wrapped;
    scan_phase = PH_SPACE;
    num_base = '0;
    num_negative = 1'b0;
    num_acc = '0;
    chars_taken = '0;
    num_wrapped = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Character driver.
  always @(posedge clk) begin
    out_item_t res;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_char(in_item, res)) expected_results.push_back(res);
      end
      if (in_valid && in_stall) begin
        // A stalled item stays on the bus unchanged.
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_chars.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= pending_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value=%h consumed=%0d overflow=%b",
                     out_item.value, out_item.consumed, out_item.overflow);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.value !== want.value || out_item.consumed !== want.consumed ||
              out_item.overflow !== want.overflow) begin
            if (mismatches < 10)
              $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       want.value, want.consumed, want.overflow,
                       out_item.value, out_item.consumed, out_item.overflow);
            mismatches++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // Long receiver hold-off so that the parser backs up and stalls its input.
  initial begin
    forever begin
      @(pressure_go);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  task automatic queue_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.ch = c;
    it.last_char = last;
    pending_chars.push_back(it);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] space_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
  endfunction

  // Mostly well-formed numbers for the current radix, with some noise.
  task automatic queue_random_string(input int max_digits);
    logic [7:0] chars[$];
    int eff;
    int gen_base;
    int v;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) chars.push_back(space_char());
      if ($urandom_range(0, 2) == 0) chars.push_back($urandom_range(0, 1) ? "-" : "+");
      eff = int'((radix_cfg > RADIX_MAX) ? RADIX_MAX : radix_cfg);
      gen_base = (eff == 0) ? int'(BASE_DEC) : eff;
      if ((eff == 0 || eff == BASE_HEX) && $urandom_range(0, 2) == 0) begin
        chars.push_back("0");
        if ($urandom_range(0, 3) != 0) begin
          chars.push_back($urandom_range(0, 1) ? "x" : "X");
          gen_base = int'(BASE_HEX);
        end else if (eff == 0) begin
          gen_base = int'(BASE_OCT);
        end
      end
      repeat ($urandom_range(0, max_digits)) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35) : $urandom_range(0, gen_base - 1);
        chars.push_back(digit_char(v));
      end
      case ($urandom_range(0, 5))
        0: chars.push_back(CHAR_NUL);
        1: chars.push_back(8'($urandom_range(0, 255)));
        2: begin
          chars.push_back(8'($urandom_range(0, 255)));
          chars.push_back(digit_char($urandom_range(0, 9)));
        end
        default: ;
      endcase
      if (chars.size() == 0) chars.push_back(digit_char(0));
    end
    foreach (chars[i]) queue_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RADIX) radix_cfg = data;
    else signed_cfg = data[0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int rdx, input int sgn, input int n_strings,
                           input int max_digits, input bit idling);
    write_reg(CFG_RADIX, CFG_DATA_BITS'(rdx));
    write_reg(CFG_SIGNED_MODE, CFG_DATA_BITS'(sgn));
    @(negedge clk);
    idle_on = idling;
    repeat (n_strings) queue_random_string(max_digits);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: auto radix with sign, prefix, octal, bare sign, stop
    // characters, a zero byte inside the digits and the top character code.
    write_reg(CFG_RADIX, '0);
    write_reg(CFG_SIGNED_MODE, CFG_DATA_BITS'(1));
    @(negedge clk);
    queue_text("\t -0x1f");
    queue_text("0x");
    queue_text("017");
    queue_text("+");
    queue_text("9z");
    queue_char("5", 1'b0);
    queue_char(CHAR_NUL, 1'b0);
    queue_char("7", 1'b1);
    queue_char(8'hFF, 1'b1);
    wait_drained();

    // Directed: a sign in unsigned mode, and a hex zero without x.
    write_reg(CFG_RADIX, BASE_HEX);
    write_reg(CFG_SIGNED_MODE, '0);
    @(negedge clk);
    queue_text("-5");
    queue_text("0a");
    wait_drained();

    run_phase(10, 1, 22, 12, 1'b1);
    run_phase(0, 1, 22, 12, 1'b1);
    run_phase(16, 0, 22, 10, 1'b1);
    run_phase(36, 1, 18, 8, 1'b1);
    run_phase(1, 0, 14, 6, 1'b1);
    run_phase(63, 1, 18, 8, 1'b1);
    run_phase(2, 1, 10, 40, 1'b1);
    run_phase(0, 0, 18, 12, 1'b0);
    run_phase(8, 1, 18, 13, 1'b1);

    // Many short strings with the receiver held off.
    write_reg(CFG_RADIX, BASE_DEC);
    write_reg(CFG_SIGNED_MODE, CFG_DATA_BITS'(1));
    @(negedge clk);
    idle_on = 1'b0;
    -> pressure_go;
    repeat (130) queue_random_string(1);
    wait_drained();

    // Last part without idling.
    run_phase(37, 0, 18, 12, 1'b0);

    @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
